### rtl/inactivity_alarm_countdown_timer_macros.svh
// Assertion macros for the inactivity alarm countdown timer.
// No dependencies; SYNTH drops every check to an empty body.
`ifndef INACTIVITY_ALARM_COUNTDOWN_TIMER_MACROS_SVH
`define INACTIVITY_ALARM_COUNTDOWN_TIMER_MACROS_SVH

`ifndef SYNTH
`define IACT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IACT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IACT_ASSERT(lbl, prop, msg)
`define IACT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/iact_pkg.sv
// Shared types and constants for the inactivity alarm countdown timer.
// No dependencies; imported by every module of the block.
package iact_pkg;

    localparam int TICKS_PER_SECOND = 4;
    localparam int PRESCALE_W       = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int SEC_PER_MIN      = 60;
    localparam int BEEP_BELOW       = 6;

    localparam int MIN_W      = 11;
    localparam int SEC_W      = 16;
    localparam int CD_W       = 8;
    localparam int INTERVAL_W = 17;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONE_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_CD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONE_EN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_EN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_EN        = 3'd6;

    // Sound codes
    localparam logic [1:0] SOUND_NONE  = 2'd0;
    localparam logic [1:0] SOUND_BEEP  = 2'd1;
    localparam logic [1:0] SOUND_ALARM = 2'd2;

    typedef struct packed {
        logic powered;
        logic charger_present;
        logic lone_restart;
        logic still_restart;
        logic fall_restart;
    } in_item_t;

    typedef struct packed {
        logic       second_pulse;
        logic [1:0] lone_sound;
        logic [1:0] still_sound;
        logic [1:0] fall_sound;
        logic       lone_sos;
        logic       still_sos;
        logic       fall_sos;
        logic       emergency_call;
        logic       lone_alarming;
        logic       still_alarming;
        logic       fall_alarming;
    } out_item_t;

    // Reload values and enables seen by the channels
    typedef struct packed {
        logic [INTERVAL_W-1:0] lone_reload;
        logic [INTERVAL_W-1:0] still_reload;
        logic [INTERVAL_W-1:0] fall_reload;
        logic [CD_W-1:0]       cd_reload;
        logic                  lone_enable;
        logic                  still_enable;
        logic                  fall_enable;
    } cfg_view_t;

    typedef struct packed {
        logic step;     // powered tick processed this cycle
        logic second;   // that tick completes a second
        logic restart;
        logic enable;
    } chan_ctl_t;

    typedef struct packed {
        logic [1:0] sound;
        logic       sos;
        logic       active;   // state after this tick
    } chan_stat_t;

endpackage

### rtl/iact_cfg.sv
// Configuration registers and derived reload values.
// Depends on iact_pkg.
module iact_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [iact_pkg::CFG_IDX_W-1:0] index,
    input  logic [iact_pkg::CFG_DATA_W-1:0] data,
    output iact_pkg::cfg_view_t            view
);
    import iact_pkg::*;

    logic [MIN_W-1:0] lone_min_reg;
    logic [MIN_W-1:0] still_min_reg;
    logic [SEC_W-1:0] fall_sec_reg;
    logic [CD_W-1:0]  alarm_cd_reg;
    logic             lone_en_reg;
    logic             still_en_reg;
    logic             fall_en_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            lone_min_reg  <= MIN_W'(30);
            still_min_reg <= MIN_W'(30);
            fall_sec_reg  <= SEC_W'(60);
            alarm_cd_reg  <= CD_W'(30);
            lone_en_reg   <= 1'b0;
            still_en_reg  <= 1'b0;
            fall_en_reg   <= 1'b0;
        end
        else if (we)
        begin
            unique case (index)
                REG_LONE_INTERVAL:  lone_min_reg  <= data[MIN_W-1:0];
                REG_STILL_INTERVAL: still_min_reg <= data[MIN_W-1:0];
                REG_FALL_INTERVAL:  fall_sec_reg  <= data[SEC_W-1:0];
                REG_ALARM_CD:       alarm_cd_reg  <= data[CD_W-1:0];
                REG_LONE_EN:        lone_en_reg   <= data[0];
                REG_STILL_EN:       still_en_reg  <= data[0];
                REG_FALL_EN:        fall_en_reg   <= data[0];
                default: ;
            endcase
        end
    end

    // minutes * 60 as (m << 6) - (m << 2)
    function automatic logic [INTERVAL_W-1:0] min_to_sec(input logic [MIN_W-1:0] m);
        logic [INTERVAL_W-1:0] w;
        w = INTERVAL_W'(m);
        return (w << 6) - (w << 2);
    endfunction

    always_comb begin
        view.lone_reload  = min_to_sec(lone_min_reg);
        view.still_reload = min_to_sec(still_min_reg);
        view.fall_reload  = INTERVAL_W'(fall_sec_reg);
        // saturate the stored-plus-one countdown
        view.cd_reload    = (&alarm_cd_reg) ? alarm_cd_reg : alarm_cd_reg + CD_W'(1);
        view.lone_enable  = lone_en_reg;
        view.still_enable = still_en_reg;
        view.fall_enable  = fall_en_reg;
    end

endmodule

### rtl/iact_chan.sv
// One safety channel: interval countdown, alarm countdown, restart latch.
// Depends on iact_pkg.
module iact_chan (
    input  logic                             clk,
    input  logic                             rst_n,
    input  iact_pkg::chan_ctl_t              ctl,
    input  logic [iact_pkg::INTERVAL_W-1:0]  interval_reload,
    input  logic [iact_pkg::CD_W-1:0]        cd_reload,
    output iact_pkg::chan_stat_t             stat
);
    import iact_pkg::*;

    logic [INTERVAL_W-1:0] ivl_reg, ivl_next;
    logic [CD_W-1:0]       cd_reg, cd_next;
    logic                  act_reg, act_next;
    logic                  pend_reg, pend_next;

    logic                  pend_eff;
    logic [INTERVAL_W-1:0] ivl0;
    logic [CD_W-1:0]       cd0;
    logic                  act0;
    logic [CD_W-1:0]       cd_dec;

    always_comb begin
        ivl_next    = ivl_reg;
        cd_next     = cd_reg;
        act_next    = act_reg;
        pend_next   = pend_reg;
        stat.sound  = SOUND_NONE;
        stat.sos    = 1'b0;

        pend_eff = pend_reg | (ctl.step & ctl.restart);
        // apply a pending restart before the channel runs
        ivl0   = pend_eff ? interval_reload : ivl_reg;
        cd0    = pend_eff ? cd_reload : cd_reg;
        act0   = pend_eff ? 1'b0 : act_reg;
        cd_dec = cd0 - CD_W'(1);

        if (ctl.step && ctl.second)
        begin
            pend_next = 1'b0;
            ivl_next  = ivl0;
            cd_next   = cd0;
            act_next  = act0;
            if (!ctl.enable)
            begin
                ivl_next = interval_reload;
                cd_next  = cd_reload;
                act_next = 1'b0;
            end
            else if (!act0)
            begin
                if (ivl0 != '0)
                begin
                    ivl_next = ivl0 - INTERVAL_W'(1);
                end
                else
                begin
                    act_next   = 1'b1;
                    stat.sound = SOUND_ALARM;
                    ivl_next   = interval_reload;
                    cd_next    = cd_reload;
                end
            end
            else if (cd0 != '0)
            begin
                cd_next = cd_dec;
                if (cd_dec < CD_W'(BEEP_BELOW) && cd_dec[0])
                begin
                    stat.sound = SOUND_BEEP;
                end
            end
            else
            begin
                // countdown spent: raise SOS and re-arm next second
                act_next  = 1'b0;
                stat.sos  = 1'b1;
                pend_next = 1'b1;
            end
        end
        else if (ctl.step)
        begin
            pend_next = pend_eff;
        end

        stat.active = act_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            ivl_reg  <= '0;
            cd_reg   <= '0;
            act_reg  <= 1'b0;
            pend_reg <= 1'b1;
        end
        else
        begin
            ivl_reg  <= ivl_next;
            cd_reg   <= cd_next;
            act_reg  <= act_next;
            pend_reg <= pend_next;
        end
    end

endmodule

### rtl/inactivity_alarm_countdown_timer.sv
// Inactivity alarm countdown timer: input register, three channels, result register.
// An accepted request waits in the input register; its result is then registered in the result register.
// Throughput: one request per cycle; a stalled result blocks acceptance only once the
// input register and the result register are both full.
// Reset (async, active low): config to defaults, counters clear, restarts pending.
// Depends on iact_pkg, iact_cfg, iact_chan and the assertion macro header.
`include "inactivity_alarm_countdown_timer_macros.svh"

module inactivity_alarm_countdown_timer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [iact_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iact_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  iact_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output iact_pkg::out_item_t             out_data
);
    import iact_pkg::*;

    logic                  s1_valid_reg, s1_valid_next;
    in_item_t              s1_reg;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;

    logic       proc;
    logic       step;
    logic       second;
    cfg_view_t  cfg;
    chan_ctl_t  lone_ctl, still_ctl, fall_ctl;
    chan_stat_t lone_st, still_st, fall_st;

    iact_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .view  (cfg)
    );

    // process the held request when the result register can take it
    assign proc     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || proc;
    assign step     = proc && s1_reg.powered;
    assign second   = step && (prescale_reg == PRESCALE_W'(TICKS_PER_SECOND - 1));

    always_comb begin
        prescale_next = prescale_reg;
        if (step)
        begin
            prescale_next = second ? '0 : prescale_reg + PRESCALE_W'(1);
        end
    end

    always_comb begin
        lone_ctl  = '{step: step, second: second, restart: s1_reg.lone_restart,
                      enable: cfg.lone_enable};
        still_ctl = '{step: step, second: second, restart: s1_reg.still_restart,
                      enable: cfg.still_enable && !cfg.fall_enable};
        fall_ctl  = '{step: step, second: second, restart: s1_reg.fall_restart,
                      enable: cfg.fall_enable && !s1_reg.charger_present};
    end

    iact_chan u_lone (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (lone_ctl),
        .interval_reload (cfg.lone_reload),
        .cd_reload       (cfg.cd_reload),
        .stat            (lone_st)
    );

    iact_chan u_still (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (still_ctl),
        .interval_reload (cfg.still_reload),
        .cd_reload       (cfg.cd_reload),
        .stat            (still_st)
    );

    iact_chan u_fall (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (fall_ctl),
        .interval_reload (cfg.fall_reload),
        .cd_reload       (cfg.cd_reload),
        .stat            (fall_st)
    );

    always_comb begin
        out_next.second_pulse   = second;
        out_next.lone_sound     = lone_st.sound;
        out_next.still_sound    = still_st.sound;
        out_next.fall_sound     = fall_st.sound;
        out_next.lone_sos       = lone_st.sos;
        out_next.still_sos      = still_st.sos;
        out_next.fall_sos       = fall_st.sos;
        out_next.emergency_call = lone_st.sos | still_st.sos | fall_st.sos;
        out_next.lone_alarming  = lone_st.active;
        out_next.still_alarming = still_st.active;
        out_next.fall_alarming  = fall_st.active;
    end

    assign s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !proc);
    assign out_valid_next = proc || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prescale_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            prescale_reg  <= prescale_next;
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        if (in_valid && in_ready)
        begin
            s1_reg <= in_data;
        end
        if (proc)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `IACT_ASSERT(a_call_is_or,
        out_valid |-> (out_data.emergency_call ==
            (out_data.lone_sos || out_data.still_sos || out_data.fall_sos)),
        "emergency_call disagrees with channel SOS")
    `IACT_ASSERT(a_call_on_second,
        out_valid && out_data.emergency_call |-> out_data.second_pulse,
        "SOS outside a completed second")
    `IACT_NEVER(a_sos_clears_alarm,
        out_valid && out_data.lone_sos && out_data.lone_alarming,
        "lone SOS with alarm still active")
    `IACT_ASSERT(a_stall_only_full,
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready),
        "input stalled with room in the pipeline")

endmodule

### tb/inactivity_alarm_countdown_timer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the inactivity alarm countdown timer.
// Sends tick requests, predicts each status word with its own channel model
// and checks it; depends on iact_pkg and the timer RTL only.
module inactivity_alarm_countdown_timer_test;
    import iact_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 125;

    typedef enum int {CH_LONE = 0, CH_STILL = 1, CH_FALL = 2} chan_e;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    // Settings copy and channel state of the predictor
    logic [MIN_W-1:0]      lone_min, still_min;
    logic [SEC_W-1:0]      fall_sec;
    logic [CD_W-1:0]       alarm_sec;
    logic                  lone_on, still_on, fall_on;
    int                    prescale;
    logic [INTERVAL_W-1:0] interval_left  [3];
    logic [CD_W-1:0]       countdown_left [3];
    logic                  alarm_active   [3];
    logic                  restart_due    [3];

    in_item_t  tick_queue[$];
    out_item_t expected_status[$];

    logic in_fire    = 1'b0;
    logic calm       = 1'b0;
    int   send_gap   = 0;
    int   stall_left = 0;
    int   idle_pct   = 0;
    int   stall_pct  = 0;
    int   stuck_cycles = 0;
    int   bad_results  = 0;
    int   requests_taken  = 0;
    int   results_checked = 0;
    int   seconds_seen = 0;
    int   alarms_seen  = 0;
    int   beeps_seen   = 0;
    int   sos_seen     = 0;
    int   settings_used = 0;

    inactivity_alarm_countdown_timer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [CD_W-1:0] countdown_reload();
        return (alarm_sec == 8'hFF) ? 8'hFF : alarm_sec + 8'd1;
    endfunction

    function automatic logic [INTERVAL_W-1:0] interval_reload(int c);
        logic [INTERVAL_W-1:0] span;
        case (c)
            CH_LONE:  span = INTERVAL_W'(lone_min * SEC_PER_MIN);
            CH_STILL: span = INTERVAL_W'(still_min * SEC_PER_MIN);
            default:  span = INTERVAL_W'(fall_sec);
        endcase
        return span;
    endfunction

    task automatic rearm(int c);
        interval_left[c]  = interval_reload(c);
        countdown_left[c] = countdown_reload();
        alarm_active[c]   = 1'b0;
    endtask

    task automatic run_second(input int c, input logic en,
                              output logic [1:0] sound, output logic sos);
        sound = SOUND_NONE;
        sos   = 1'b0;
        if (!en)
        begin
            rearm(c);
        end
        else if (!alarm_active[c])
        begin
            if (interval_left[c] != 0)
                interval_left[c] = interval_left[c] - 1'b1;
            else
            begin
                alarm_active[c]   = 1'b1;
                sound             = SOUND_ALARM;
                interval_left[c]  = interval_reload(c);
                countdown_left[c] = countdown_reload();
            end
        end
        else if (countdown_left[c] != 0)
        begin
            countdown_left[c] = countdown_left[c] - 1'b1;
            if (countdown_left[c] < BEEP_BELOW && countdown_left[c][0])
                sound = SOUND_BEEP;
        end
        else
        begin
            alarm_active[c] = 1'b0;
            sos             = 1'b1;
            restart_due[c]  = 1'b1;
        end
    endtask

    task automatic predict_tick(input in_item_t req, output out_item_t res);
        res = '0;
        if (req.powered)
        begin
            restart_due[CH_LONE]  = restart_due[CH_LONE] | req.lone_restart;
            restart_due[CH_STILL] = restart_due[CH_STILL] | req.still_restart;
            restart_due[CH_FALL]  = restart_due[CH_FALL] | req.fall_restart;
            prescale = prescale + 1;
            if (prescale >= TICKS_PER_SECOND)
            begin
                prescale = 0;
                res.second_pulse = 1'b1;
                // pending restarts go first, then the channels run
                for (int c = 0; c < 3; c++)
                begin
                    if (restart_due[c])
                    begin
                        restart_due[c] = 1'b0;
                        rearm(c);
                    end
                end
                run_second(CH_LONE, lone_on, res.lone_sound, res.lone_sos);
                run_second(CH_STILL, still_on && !fall_on, res.still_sound, res.still_sos);
                run_second(CH_FALL, fall_on && !req.charger_present,
                           res.fall_sound, res.fall_sos);
                res.emergency_call = res.lone_sos | res.still_sos | res.fall_sos;
            end
        end
        res.lone_alarming  = alarm_active[CH_LONE];
        res.still_alarming = alarm_active[CH_STILL];
        res.fall_alarming  = alarm_active[CH_FALL];
    endtask

    function automatic string show_status(out_item_t s);
        return $sformatf("sec=%0d snd=%0d/%0d/%0d sos=%0d/%0d/%0d call=%0d alarm=%0d/%0d/%0d",
                         s.second_pulse, s.lone_sound, s.still_sound, s.fall_sound,
                         s.lone_sos, s.still_sos, s.fall_sos, s.emergency_call,
                         s.lone_alarming, s.still_alarming, s.fall_alarming);
    endfunction

    function automatic in_item_t make_tick(logic pwr, logic chg, logic lr, logic sr,
                                           logic fr);
        return {pwr, chg, lr, sr, fr};
    endfunction

    function automatic in_item_t random_tick(int noise_pct);
        in_item_t t;
        if ($urandom_range(99) < noise_pct)
            t = in_item_t'(5'($urandom_range(31)));
        else
            t = make_tick($urandom_range(99) < 94, $urandom_range(99) < 12,
                          $urandom_range(99) < 1, $urandom_range(99) < 1,
                          $urandom_range(99) < 1);
        return t;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic apply_settings(logic [MIN_W-1:0] lone, logic [MIN_W-1:0] still,
                                  logic [SEC_W-1:0] fall, logic [CD_W-1:0] cd,
                                  logic le, logic se, logic fe);
        lone_min  = lone;
        still_min = still;
        fall_sec  = fall;
        alarm_sec = cd;
        lone_on   = le;
        still_on  = se;
        fall_on   = fe;
        settings_used++;
        write_reg(REG_LONE_INTERVAL, {5'd0, lone});
        write_reg(REG_STILL_INTERVAL, {5'd0, still});
        write_reg(REG_FALL_INTERVAL, fall);
        write_reg(REG_ALARM_CD, {8'd0, cd});
        write_reg(REG_LONE_EN, {15'd0, le});
        write_reg(REG_STILL_EN, {15'd0, se});
        write_reg(REG_FALL_EN, {15'd0, fe});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every status word is back
    task automatic drain();
        while (tick_queue.size() != 0 || in_valid || expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Request driver: hold each request until taken, then maybe pause
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                in_data  <= tick_queue.pop_front();
                in_valid <= 1'b1;
                if (!calm && $urandom_range(99) < idle_pct)
                    send_gap <= $urandom_range(1, 4);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        out_item_t next_status;
        in_fire <= in_valid && in_ready;
        // check results before predicting, so a result can never match
        // the request taken at the same edge
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                bad_results++;
                if (bad_results <= REPORT_MAX)
                    $display("unexpected status word: %s", show_status(out_data));
            end
            else
            begin
                want = expected_status.pop_front();
                results_checked++;
                if (out_data !== want)
                begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX)
                        $display("status %0d mismatch\n  expected %s\n  actual   %s",
                                 results_checked, show_status(want), show_status(out_data));
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            predict_tick(in_data, next_status);
            expected_status.push_back(next_status);
            requests_taken++;
            seconds_seen += next_status.second_pulse;
            sos_seen     += next_status.lone_sos + next_status.still_sos
                            + next_status.fall_sos;
            alarms_seen  += (next_status.lone_sound == SOUND_ALARM)
                            + (next_status.still_sound == SOUND_ALARM)
                            + (next_status.fall_sound == SOUND_ALARM);
            beeps_seen   += (next_status.lone_sound == SOUND_BEEP)
                            + (next_status.still_sound == SOUND_BEEP)
                            + (next_status.fall_sound == SOUND_BEEP);
        end
    end

    // Watchdog: work is outstanding but nothing moves
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (tick_queue.size() == 0 && !in_valid && expected_status.size() == 0))
            stuck_cycles <= 0;
        else if (stuck_cycles >= IDLE_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d status words outstanding",
                     IDLE_LIMIT, expected_status.size());
            $display("inactivity_alarm_countdown_timer_test: FAIL");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        logic [MIN_W-1:0] lone_v, still_v;
        logic [SEC_W-1:0] fall_v;
        logic [CD_W-1:0]  cd_v;
        int               roll;

        // Predictor reset state matches the block's reset
        lone_min  = 11'd30;
        still_min = 11'd30;
        fall_sec  = 16'd60;
        alarm_sec = 8'd30;
        lone_on   = 1'b0;
        still_on  = 1'b0;
        fall_on   = 1'b0;
        prescale  = 0;
        for (int c = 0; c < 3; c++)
        begin
            interval_left[c]  = '0;
            countdown_left[c] = '0;
            alarm_active[c]   = 1'b0;
            restart_due[c]    = 1'b1;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: every channel disabled; power-off restarts are dropped
        tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        drain();

        // Zero intervals, one-second countdown: alarm, beep, SOS, re-arm
        apply_settings(11'd0, 11'd0, 16'd0, 8'd1, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < 16; i++)
        begin
            if (i == 7)
                tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1));
            tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        end
        tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        drain();

        // Largest settings, then the saturating countdown
        idle_pct  = 30;
        stall_pct = 30;
        apply_settings(11'd1440, 11'd1440, 16'hFFFF, 8'd254, 1'b1, 1'b0, 1'b1);
        for (int i = 0; i < 50; i++)
            tick_queue.push_back(random_tick(10));
        drain();
        apply_settings(11'd0, 11'd0, 16'd0, 8'd255, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 50; i++)
            tick_queue.push_back(random_tick(10));
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            roll   = $urandom_range(99);
            lone_v = (roll < 70) ? 11'd0 : (roll < 90) ? 11'd1 : 11'($urandom_range(1440));
            roll    = $urandom_range(99);
            still_v = (roll < 70) ? 11'd0 : (roll < 90) ? 11'd1 : 11'($urandom_range(1440));
            roll   = $urandom_range(99);
            fall_v = (roll < 60) ? 16'($urandom_range(6)) :
                     (roll < 90) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(65535));
            roll = $urandom_range(99);
            cd_v = (roll < 60) ? 8'($urandom_range(8)) :
                   (roll < 90) ? 8'($urandom_range(9, 30)) : 8'd254;
            apply_settings(lone_v, still_v, fall_v, cd_v, 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            idle_pct  = 25 * $urandom_range(2);
            stall_pct = 25 * $urandom_range(2);
            calm      = (phase == RANDOM_PHASES - 1);
            for (int i = 0; i < PHASE_TICKS; i++)
                tick_queue.push_back(random_tick(10));
            drain();
        end

        repeat (8) @(negedge clk);
        if (expected_status.size() != 0)
        begin
            $display("%0d status words never arrived", expected_status.size());
            bad_results += expected_status.size();
        end
        $display("ran %0d tick requests under %0d settings: %0d seconds, %0d alarm starts,",
                 requests_taken, settings_used, seconds_seen, alarms_seen);
        $display("  %0d beeps, %0d SOS pulses; %0d status words checked, %0d bad",
                 beeps_seen, sos_seen, results_checked, bad_results);
        if (bad_results == 0)
            $display("inactivity_alarm_countdown_timer_test: PASS");
        else
            $display("inactivity_alarm_countdown_timer_test: FAIL");
        $finish;
    end

endmodule
